FILE: hdl/biquad_highpass_df2t_core_defines.svh
// assertion macros for the biquad high-pass core checker
`ifndef BIQUAD_HIGHPASS_DF2T_CORE_DEFINES_SVH
`define BIQUAD_HIGHPASS_DF2T_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BIQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("biquad core assertion failed");

// next-cycle implication, disabled during reset
`define BIQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("biquad core assertion failed");

`endif

FILE: hdl/biq_pkg.sv
// shared types, constants, microcode rom and arithmetic helpers for the biquad core
`default_nettype none

package biq_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 32;
  localparam int DELAY_W    = SAMPLE_W + COEF_W;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = DELAY_W + 2;
  localparam int COEF_FRAC  = COEF_W - 4;
  localparam int NUM_COEFS  = 5;
  localparam int CFG_IDX_W  = $clog2(NUM_COEFS);
  localparam int STEP_W     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_B0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_B1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_B2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_A1 = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_A2 = CFG_IDX_W'(4);

  localparam logic signed [COEF_W-1:0] B0_RST = COEF_W'(266455076);
  localparam logic signed [COEF_W-1:0] B1_RST = COEF_W'(-532910152);
  localparam logic signed [COEF_W-1:0] B2_RST = COEF_W'(266455076);
  localparam logic signed [COEF_W-1:0] A1_RST = COEF_W'(-532895511);
  localparam logic signed [COEF_W-1:0] A2_RST = COEF_W'(264489293);

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC - 1);
  localparam logic signed [SAMPLE_W-1:0] SAMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [DELAY_W-1:0] DLY_MAX = {1'b0, {(DELAY_W-1){1'b1}}};
  localparam logic signed [DELAY_W-1:0] DLY_MIN = {1'b1, {(DELAY_W-1){1'b0}}};

  localparam logic [STEP_W-1:0] STEP_WAIT   = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_MUL_B0 = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_ACC_D1 = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_OUT_Y  = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_MUL_A1 = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_SUB_A1 = STEP_W'(5);
  localparam logic [STEP_W-1:0] STEP_WR_D1  = STEP_W'(6);
  localparam logic [STEP_W-1:0] STEP_SUB_A2 = STEP_W'(7);
  localparam logic [STEP_W-1:0] STEP_WR_D2  = STEP_W'(8);

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_WAIT_IN,
    COND_WAIT_OUT,
    COND_END
  } cond_t;

  typedef enum logic [2:0] {
    ACC_NOP,
    ACC_LD,
    ACC_LD_D1,
    ACC_LD_D2,
    ACC_SUB
  } acc_op_t;

  typedef struct packed {
    logic                 take_in;
    cond_t                cond;
    logic [CFG_IDX_W-1:0] coef_sel;
    logic                 use_y;
    acc_op_t              acc_op;
    logic                 wr_y;
    logic                 wr_d1;
    logic                 wr_d2;
  } ucode_t;

  typedef struct packed {
    ucode_t word;
    logic   adv;
  } seq_ctrl_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{take_in: 1'b0, cond: COND_NEXT, coef_sel: REG_B0, use_y: 1'b0,
          acc_op: ACC_NOP, wr_y: 1'b0, wr_d1: 1'b0, wr_d2: 1'b0};
    case (step)
      STEP_WAIT: begin
        w.take_in = 1'b1;
        w.cond    = COND_WAIT_IN;
      end
      STEP_MUL_B0: begin
        w.coef_sel = REG_B0;
      end
      STEP_ACC_D1: begin
        w.acc_op   = ACC_LD_D1;
        w.coef_sel = REG_B1;
      end
      STEP_OUT_Y: begin
        w.wr_y   = 1'b1;
        w.acc_op = ACC_LD_D2;
        w.cond   = COND_WAIT_OUT;
      end
      STEP_MUL_A1: begin
        w.coef_sel = REG_A1;
        w.use_y    = 1'b1;
      end
      STEP_SUB_A1: begin
        w.acc_op   = ACC_SUB;
        w.coef_sel = REG_B2;
      end
      STEP_WR_D1: begin
        w.wr_d1    = 1'b1;
        w.acc_op   = ACC_LD;
        w.coef_sel = REG_A2;
        w.use_y    = 1'b1;
      end
      STEP_SUB_A2: begin
        w.acc_op = ACC_SUB;
      end
      STEP_WR_D2: begin
        w.wr_d2 = 1'b1;
        w.cond  = COND_END;
      end
      default: begin
        w.cond = COND_END;
      end
    endcase
    return w;
  endfunction

  // round half up at the q4.28 coefficient point, clamp to the q1.23 sample range
  function automatic logic signed [SAMPLE_W-1:0] round_sat_sample(
    input logic signed [ACC_W-1:0] a
  );
    logic signed [ACC_W-1:0] s;
    s = (a + ROUND_HALF) >>> COEF_FRAC;
    if (s > ACC_W'(SAMP_MAX)) begin
      return SAMP_MAX;
    end else if (s < ACC_W'(SAMP_MIN)) begin
      return SAMP_MIN;
    end
    return SAMPLE_W'(s);
  endfunction

  function automatic logic signed [DELAY_W-1:0] sat_delay(
    input logic signed [ACC_W-1:0] a
  );
    if (a > ACC_W'(DLY_MAX)) begin
      return DLY_MAX;
    end else if (a < ACC_W'(DLY_MIN)) begin
      return DLY_MIN;
    end
    return DELAY_W'(a);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/biq_ifs.sv
// valid/ready stream interfaces for the sample input and the filtered output
`default_nettype none

interface biq_in_if
  import biq_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       block_end_in;

  modport source (output valid, output sample_in, output block_end_in, input ready);
  modport sink (input valid, input sample_in, input block_end_in, output ready);
endinterface

interface biq_out_if
  import biq_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       block_end_out;

  modport source (output valid, output sample_out, output block_end_out, input ready);
  modport sink (input valid, input sample_out, input block_end_out, output ready);
endinterface

`default_nettype wire

FILE: hdl/biq_seq.sv
// microcode sequencer: step counter, control rom and conditional jumps
`default_nettype none

module biq_seq
  import biq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire dp_stat_t  stat,
  output seq_ctrl_t      ctrl,
  output logic           in_ready
);

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  ucode_t            word;
  logic              adv;

  always_comb begin
    word     = ucode_rom(step_r);
    adv      = 1'b1;
    step_nxt = step_r + 1'b1;
    case (word.cond)
      COND_NEXT:     adv = 1'b1;
      COND_WAIT_IN:  adv = in_valid;
      COND_WAIT_OUT: adv = stat.out_free;
      COND_END:      step_nxt = STEP_WAIT;
      default:       step_nxt = STEP_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_WAIT;
    end else if (adv) begin
      step_r <= step_nxt;
    end
  end

  assign ctrl.word = word;
  assign ctrl.adv  = adv;
  assign in_ready  = word.take_in;

endmodule

`default_nettype wire

FILE: hdl/biq_datapath.sv
// coefficient registers, shared multiplier, accumulator, delay state and output register
`default_nettype none

module biq_datapath
  import biq_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire seq_ctrl_t                  ctrl,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [COEF_W-1:0]          cfg_data,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  input  wire logic                       in_blk,
  input  wire logic                       out_ready,
  output logic                            out_valid,
  output logic signed [SAMPLE_W-1:0]      out_sample,
  output logic                            out_blk,
  output dp_stat_t                        stat
);

  logic signed [COEF_W-1:0]   coef_r [NUM_COEFS];
  logic signed [SAMPLE_W-1:0] x_r;
  logic                       blk_r;
  logic signed [SAMPLE_W-1:0] y_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ACC_W-1:0]    acc_nxt;
  logic signed [DELAY_W-1:0]  d1_r;
  logic signed [DELAY_W-1:0]  d2_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_blk_r;

  logic signed [COEF_W-1:0]   coef_op;
  logic signed [SAMPLE_W-1:0] data_op;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [SAMPLE_W-1:0] y_nxt;

  always_comb begin
    coef_op  = (ctrl.word.coef_sel < NUM_COEFS) ? coef_r[ctrl.word.coef_sel] : '0;
    data_op  = ctrl.word.use_y ? y_r : x_r;
    prod_nxt = PROD_W'(coef_op) * PROD_W'(data_op);
    prod_ext = ACC_W'(prod_r);
    y_nxt    = round_sat_sample(acc_r);
    case (ctrl.word.acc_op)
      ACC_NOP:   acc_nxt = acc_r;
      ACC_LD:    acc_nxt = prod_ext;
      ACC_LD_D1: acc_nxt = prod_ext + ACC_W'(d1_r);
      ACC_LD_D2: acc_nxt = prod_ext + ACC_W'(d2_r);
      ACC_SUB:   acc_nxt = acc_r - prod_ext;
      default:   acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[REG_B0] <= B0_RST;
      coef_r[REG_B1] <= B1_RST;
      coef_r[REG_B2] <= B2_RST;
      coef_r[REG_A1] <= A1_RST;
      coef_r[REG_A2] <= A2_RST;
    end else if (cfg_we && (cfg_idx < NUM_COEFS)) begin
      coef_r[cfg_idx] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r        <= '0;
      d2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.adv && ctrl.word.wr_d1) begin
        d1_r <= sat_delay(acc_r);
      end
      if (ctrl.adv && ctrl.word.wr_d2) begin
        d2_r <= sat_delay(acc_r);
      end
      if (ctrl.adv && ctrl.word.wr_y) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv && ctrl.word.take_in) begin
      x_r   <= in_sample;
      blk_r <= in_blk;
    end
    if (ctrl.adv) begin
      prod_r <= prod_nxt;
      acc_r  <= acc_nxt;
    end
    if (ctrl.adv && ctrl.word.wr_y) begin
      y_r          <= y_nxt;
      out_sample_r <= y_nxt;
      out_blk_r    <= blk_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sample    = out_sample_r;
  assign out_blk       = out_blk_r;
  assign stat.out_free = !out_valid_r || out_ready;

endmodule

`default_nettype wire

FILE: hdl/biquad_highpass_df2t_core.sv
// top level of the transposed direct form ii biquad high-pass core
// input passes x_r, prod_r, acc_r to the output register, stalling until it is free
// one sample at a time through the single shared 24x32 multiplier
// the 9-step microcode program performs five products and the accumulate passes
// reset: synchronous active-low rst_n clears both delay states and the output valid
// and returns all five coefficients to the 80 hz high-pass defaults
`default_nettype none

module biquad_highpass_df2t_core
  import biq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  biq_in_if.sink                    in_bus,
  biq_out_if.source                 out_bus,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [COEF_W-1:0]    cfg_data
);

  seq_ctrl_t ctrl;
  dp_stat_t  stat;
  logic      in_ready;

  biq_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .stat     (stat),
    .ctrl     (ctrl),
    .in_ready (in_ready)
  );

  biq_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .in_sample  (in_bus.sample_in),
    .in_blk     (in_bus.block_end_in),
    .out_ready  (out_bus.ready),
    .out_valid  (out_bus.valid),
    .out_sample (out_bus.sample_out),
    .out_blk    (out_bus.block_end_out),
    .stat       (stat)
  );

  assign in_bus.ready = in_ready;

endmodule

`default_nettype wire

FILE: hdl/biq_checker.sv
// port-level assertions for the biquad core and their bind to the top level
`default_nettype none
`include "biquad_highpass_df2t_core_defines.svh"

module biq_checker
  import biq_pkg::*;
(
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic signed [SAMPLE_W-1:0] out_sample,
  input wire logic                       out_blk
);

  // a stalled result stays offered
  `BIQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // a stalled result keeps its payload
  `BIQ_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_sample) && $stable(out_blk))

  // one sample at a time: busy right after taking a beat
  `BIQ_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready)

  // a fresh result only appears mid-program, never while waiting for input
  `BIQ_ASSERT_SAME(a_rise_busy, clk, rst_n, $rose(out_valid), !in_ready)

endmodule

bind biquad_highpass_df2t_core biq_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_bus.valid),
  .in_ready   (in_bus.ready),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_sample (out_bus.sample_out),
  .out_blk    (out_bus.block_end_out)
);

`default_nettype wire

FILE: tb/tb_top.sv
// self-checking testbench for the biquad high-pass core: stalls, coefficient sets, saturation
`default_nettype none

module tb_top
  import biq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     LIMIT        = 500000;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     IDLE_TAIL    = 16;
  localparam int     REPORT_MAX   = 10;
  localparam longint HALF_LSB     = longint'(1) <<< (COEF_FRAC - 1);
  localparam longint COEF_INIT [NUM_COEFS] =
    '{266455076, -532910152, 266455076, -532895511, 264489293};
  localparam logic [CFG_IDX_W-1:0] COEF_REGS [NUM_COEFS] =
    '{REG_B0, REG_B1, REG_B2, REG_A1, REG_A2};
  localparam logic [COEF_W-1:0] COEF_POS_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] COEF_NEG_MAX = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic [COEF_W-1:0] COEF_HALF    = COEF_W'(1) << (COEF_FRAC - 1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       be;
  } out_beat_t;

  class biquad_checker;
    longint    coef [NUM_COEFS];
    longint    dly_one;
    longint    dly_two;
    out_beat_t expected_q [$];
    int        accepted;
    int        checked;
    int        mismatches;

    function new();
      coef = COEF_INIT;
      dly_one = 0;
      dly_two = 0;
      accepted = 0;
      checked = 0;
      mismatches = 0;
    endfunction

    static function longint clamp(longint v, int w);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
        return hi;
      end else if (v < lo) begin
        return lo;
      end
      return v;
    endfunction

    function void set_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
      logic signed [COEF_W-1:0] c;
      c = data;
      if (idx < NUM_COEFS) begin
        coef[idx] = longint'(c);
      end
    endfunction

    // transposed direct form ii step, full precision delays
    function void take_input(logic signed [SAMPLE_W-1:0] smp, logic be);
      longint    x;
      longint    acc;
      longint    y;
      longint    nd1;
      longint    nd2;
      out_beat_t beat;
      x = longint'(smp);
      acc = coef[REG_B0] * x + dly_one;
      y = clamp((acc + HALF_LSB) >>> COEF_FRAC, SAMPLE_W);
      nd1 = coef[REG_B1] * x - coef[REG_A1] * y + dly_two;
      nd2 = coef[REG_B2] * x - coef[REG_A2] * y;
      dly_one = clamp(nd1, DELAY_W);
      dly_two = clamp(nd2, DELAY_W);
      beat.smp = y[SAMPLE_W-1:0];
      beat.be = be;
      expected_q.push_back(beat);
      accepted++;
    endfunction

    function void note_error(string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("%0t: %s", $realtime, msg);
      end
    endfunction

    function void check_output(logic signed [SAMPLE_W-1:0] smp, logic be);
      out_beat_t want;
      if (expected_q.size() == 0) begin
        note_error($sformatf("unexpected beat: sample %0d end %0b", smp, be));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want.smp !== smp || want.be !== be) begin
        note_error($sformatf("beat %0d: expected sample %0d end %0b, got sample %0d end %0b",
                             checked, want.smp, want.be, smp, be));
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [COEF_W-1:0]    cfg_data;

  biq_in_if  in_if ();
  biq_out_if out_if ();

  biquad_highpass_df2t_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_if),
    .out_bus  (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  biquad_checker     sb = new();
  bit                in_gaps_on = 1'b1;
  bit                out_gaps_on = 1'b1;
  bit                out_hold_req = 1'b0;
  int                coef_settings = 1;
  int                buf_left = 0;
  longint            walk_level = 0;
  logic [COEF_W-1:0] coef_vals [NUM_COEFS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("biquad_highpass_df2t_core test failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        sb.take_input(in_if.sample_in, in_if.block_end_in);
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_output(out_if.sample_out, out_if.block_end_out);
      end
    end
  end

  initial begin
    int gap;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (out_hold_req) begin
        gap = HOLD_CYCLES;
        out_hold_req = 1'b0;
      end else begin
        gap = out_gaps_on ? $urandom_range(0, 19) : 0;
      end
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
      @(negedge clk);
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic be);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.sample_in <= smp;
    in_if.block_end_in <= be;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (IDLE_TAIL) @(negedge clk);
  endtask

  // unused indexes get random data too, they must not disturb anything
  task automatic write_coefs();
    for (int i = 0; i < NUM_COEFS; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= COEF_REGS[i];
      cfg_data <= coef_vals[i];
      sb.set_coef(COEF_REGS[i], coef_vals[i]);
      @(negedge clk);
    end
    for (int k = NUM_COEFS; k < (1 << CFG_IDX_W); k++) begin
      cfg_we <= 1'b1;
      cfg_idx <= CFG_IDX_W'(k);
      cfg_data <= $urandom;
      sb.set_coef(CFG_IDX_W'(k), cfg_data);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    coef_settings++;
  endtask

  task automatic random_coefs(input bit full_range);
    for (int i = 0; i < NUM_COEFS; i++) begin
      if (full_range) begin
        coef_vals[i] = $urandom;
      end else begin
        coef_vals[i] = COEF_W'($urandom_range(0, 1 << 29) - (1 << 28));
      end
    end
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic signed [SAMPLE_W-1:0] s;
    case ($urandom_range(0, 9))
      0, 1, 2: s = SAMPLE_W'($urandom);
      3: s = SAMP_MAX;
      4: s = SAMP_MIN;
      5: s = SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
      6, 7, 8: begin
        walk_level += longint'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
        walk_level = biquad_checker::clamp(walk_level, SAMPLE_W);
        s = walk_level[SAMPLE_W-1:0];
      end
      default: s = SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1);
    endcase
    return s;
  endfunction

  // buffers of random length, flag on the last sample
  function automatic logic pick_end();
    if (buf_left == 0) begin
      buf_left = $urandom_range(0, 31);
      return 1'b1;
    end
    buf_left--;
    return 1'b0;
  endfunction

  task automatic run_random(input int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 39) == 0) in_gaps_on = !in_gaps_on;
      if ($urandom_range(0, 39) == 0) out_gaps_on = !out_gaps_on;
      send_sample(pick_sample(), pick_end());
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.sample_in = '0;
    in_if.block_end_in = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_B0;
    cfg_data = '0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset coefficients, extremes and alternating bit patterns
    send_sample('0, 1'b0);
    send_sample(SAMP_MAX, 1'b0);
    send_sample(SAMP_MAX, 1'b0);
    send_sample(SAMP_MIN, 1'b0);
    send_sample(SAMP_MIN, 1'b1);
    send_sample(SAMPLE_W'(1), 1'b0);
    send_sample(-SAMPLE_W'(1), 1'b0);
    send_sample(SAMPLE_W'('h555555), 1'b0);
    send_sample(SAMPLE_W'('haaaaaa), 1'b1);
    repeat (4) send_sample('0, 1'b0);
    send_sample(SAMP_MAX, 1'b1);
    send_sample(SAMP_MIN, 1'b0);
    send_sample('0, 1'b1);
    run_random(130);
    wait_idle();

    // half gain, rounding ties on odd samples
    coef_vals = '{COEF_HALF, '0, '0, '0, '0};
    write_coefs();
    send_sample(SAMPLE_W'(1), 1'b0);
    send_sample(-SAMPLE_W'(1), 1'b1);
    send_sample(SAMPLE_W'(3), 1'b0);
    send_sample(-SAMPLE_W'(3), 1'b0);
    send_sample(SAMP_MAX, 1'b1);
    send_sample(SAMP_MIN, 1'b0);
    send_sample(SAMPLE_W'(2), 1'b0);
    send_sample('0, 1'b1);
    run_random(90);
    wait_idle();

    coef_vals = '{COEF_POS_MAX, COEF_POS_MAX, COEF_POS_MAX, COEF_POS_MAX, COEF_POS_MAX};
    write_coefs();
    run_random(110);
    wait_idle();

    coef_vals = '{COEF_NEG_MAX, COEF_NEG_MAX, COEF_NEG_MAX, COEF_NEG_MAX, COEF_NEG_MAX};
    write_coefs();
    run_random(110);
    wait_idle();

    coef_vals = '{COEF_POS_MAX, COEF_POS_MAX, COEF_POS_MAX, COEF_NEG_MAX, COEF_NEG_MAX};
    write_coefs();
    run_random(90);
    wait_idle();

    coef_vals = '{COEF_NEG_MAX, COEF_NEG_MAX, COEF_NEG_MAX, COEF_POS_MAX, COEF_POS_MAX};
    write_coefs();
    run_random(90);
    wait_idle();

    coef_vals = '{'0, '0, '0, '0, '0};
    write_coefs();
    run_random(50);
    wait_idle();

    random_coefs(1'b1);
    write_coefs();
    run_random(120);
    wait_idle();

    random_coefs(1'b0);
    write_coefs();
    run_random(120);
    wait_idle();

    // back to the high-pass design, long output stall then a full drain mid-stream
    for (int i = 0; i < NUM_COEFS; i++) coef_vals[i] = COEF_W'(COEF_INIT[i]);
    write_coefs();
    out_hold_req = 1'b1;
    in_gaps_on = 1'b0;
    run_random(40);
    wait_idle();
    run_random(80);
    wait_idle();

    $display("covered %0d samples under %0d coefficient settings, %0d results checked,",
             sb.accepted, coef_settings, sb.checked);
    $display("with saturation, rounding ties, ignored register writes and a long output stall");
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("biquad_highpass_df2t_core test passed");
    end else begin
      $display("biquad_highpass_df2t_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
